// ----- rtl/core/dlbm_pkg.sv -----
`default_nettype none

package dlbm_pkg;

  // Shift register geometry
  localparam int unsigned SHORT_W   = 13;
  localparam int unsigned LONG_W    = 100;
  localparam int unsigned LONG_LO_W = 64;
  localparam int unsigned LONG_HI_W = LONG_W - LONG_LO_W;
  localparam int unsigned SHORT_TAP = 1;
  localparam int unsigned LONG_TAP  = 36;
  localparam int unsigned BYTE_W    = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_SEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SEED_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SEED_HI = 2'd2;

  // Seed reset values
  localparam logic [SHORT_W-1:0]   SHORT_SEED_RST   = 13'hD4B;
  localparam logic [LONG_LO_W-1:0] LONG_SEED_LO_RST = 64'hAAFE_BBEC_FEBA_AFCA;
  localparam logic [LONG_HI_W-1:0] LONG_SEED_HI_RST = 36'hA_BFCB_BAEA;

  // Queue between generator and output stage
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SHORT_W-1:0] short_reg;
    logic [LONG_W-1:0]  long_reg;
  } lfsr_t;

  typedef struct packed {
    lfsr_t             state;
    logic [BYTE_W-1:0] key;
  } gen_t;

  // One queued transaction: data plus its keystream byte
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] key_byte;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Eight register steps, keystream LSB first
  function automatic gen_t gen_byte(input lfsr_t cur);
    gen_t r;
    logic fb_s;
    logic fb_l;
    r.state = cur;
    r.key   = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      fb_s = r.state.short_reg[0] ^ r.state.short_reg[SHORT_TAP];
      fb_l = r.state.long_reg[0] ^ r.state.long_reg[LONG_TAP];
      r.state.short_reg = {fb_s, r.state.short_reg[SHORT_W-1:1]};
      r.state.long_reg  = {fb_l, r.state.long_reg[LONG_W-1:1]};
      r.key[k] = fb_s ^ fb_l;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dlbm_if.sv -----
`default_nettype none

// Input channel
interface dlbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Output channel
interface dlbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] masked_byte;

  modport source (output valid, output masked_byte, input ready);
  modport sink   (input valid, input masked_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dlbm_front.sv -----
`default_nettype none

module dlbm_front (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        cfg_we_i,
  input  wire  [dlbm_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  wire  [dlbm_pkg::CFG_DATA_W-1:0]            cfg_wdata_i,
  dlbm_in_if.sink                                    in_i,
  input  dlbm_pkg::q_status_t                        status_i,
  output logic                                       push_o,
  output dlbm_pkg::entry_t                           push_data_o
);

  logic [dlbm_pkg::SHORT_W-1:0]   short_seed_q, short_seed_d;
  logic [dlbm_pkg::LONG_LO_W-1:0] lo_seed_q, lo_seed_d;
  logic [dlbm_pkg::LONG_HI_W-1:0] hi_seed_q, hi_seed_d;
  dlbm_pkg::lfsr_t                lfsr_q, lfsr_d;
  dlbm_pkg::gen_t                 gen;
  logic                           cfg_hit;

  // Accept whenever the queue has room
  assign in_i.ready = !status_i.full;
  assign push_o     = in_i.valid && !status_i.full;

  assign gen                   = dlbm_pkg::gen_byte(lfsr_q);
  assign push_data_o.data_byte = in_i.data_byte;
  assign push_data_o.key_byte  = gen.key;

  // Seed writes; unknown index is ignored
  always_comb begin
    short_seed_d = short_seed_q;
    lo_seed_d    = lo_seed_q;
    hi_seed_d    = hi_seed_q;
    cfg_hit      = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dlbm_pkg::REG_SHORT_SEED: begin
          short_seed_d = cfg_wdata_i[dlbm_pkg::SHORT_W-1:0];
          cfg_hit      = 1'b1;
        end
        dlbm_pkg::REG_LONG_SEED_LO: begin
          lo_seed_d = cfg_wdata_i[dlbm_pkg::LONG_LO_W-1:0];
          cfg_hit   = 1'b1;
        end
        dlbm_pkg::REG_LONG_SEED_HI: begin
          hi_seed_d = cfg_wdata_i[dlbm_pkg::LONG_HI_W-1:0];
          cfg_hit   = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Reload on a seed write, advance one byte per transaction
  always_comb begin
    lfsr_d = lfsr_q;
    if (cfg_hit) begin
      lfsr_d.short_reg = short_seed_d;
      lfsr_d.long_reg  = {hi_seed_d, lo_seed_d};
    end else if (push_o) begin
      lfsr_d = gen.state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_seed_q     <= dlbm_pkg::SHORT_SEED_RST;
      lo_seed_q        <= dlbm_pkg::LONG_SEED_LO_RST;
      hi_seed_q        <= dlbm_pkg::LONG_SEED_HI_RST;
      lfsr_q.short_reg <= dlbm_pkg::SHORT_SEED_RST;
      lfsr_q.long_reg  <= {dlbm_pkg::LONG_SEED_HI_RST, dlbm_pkg::LONG_SEED_LO_RST};
    end else begin
      short_seed_q <= short_seed_d;
      lo_seed_q    <= lo_seed_d;
      hi_seed_q    <= hi_seed_d;
      lfsr_q       <= lfsr_d;
    end
  end

  // Checks
  a_short_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == dlbm_pkg::REG_SHORT_SEED |=>
      lfsr_q.short_reg == $past(cfg_wdata_i[dlbm_pkg::SHORT_W-1:0]))
    else $error("short register not reloaded from written seed");

  a_long_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == dlbm_pkg::REG_LONG_SEED_HI |=>
      lfsr_q.long_reg[dlbm_pkg::LONG_W-1:dlbm_pkg::LONG_LO_W] ==
      $past(cfg_wdata_i[dlbm_pkg::LONG_HI_W-1:0]))
    else $error("long register not reloaded from written seed");

endmodule

`default_nettype wire

// ----- rtl/core/dlbm_queue.sv -----
`default_nettype none

module dlbm_queue #(
  parameter int unsigned DEPTH = dlbm_pkg::QUEUE_DEPTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  dlbm_pkg::entry_t     push_data_i,
  input  wire                  pop_i,
  output dlbm_pkg::entry_t     pop_data_o,
  output dlbm_pkg::q_status_t  status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dlbm_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push_fire;
  logic              pop_fire;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign push_fire      = push_i && !status_o.full;
  assign pop_fire       = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_fire, pop_fire})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && !pop_fire |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue occupancy did not grow on push");

endmodule

`default_nettype wire

// ----- rtl/core/dlbm_back.sv -----
`default_nettype none

module dlbm_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dlbm_pkg::q_status_t  status_i,
  input  dlbm_pkg::entry_t     pop_data_i,
  output logic                 pop_o,
  dlbm_out_if.source           out_o
);

  logic                          out_valid_q, out_valid_d;
  logic [dlbm_pkg::BYTE_W-1:0]   masked_q;

  // Refill the output register when it is empty or being taken
  assign pop_o = !status_i.empty && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Apply the mask
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      masked_q <= pop_data_i.data_byte ^ pop_data_i.key_byte;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.masked_byte = masked_q;

  // Checks
  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_o.valid &&
      out_o.masked_byte == $past(pop_data_i.data_byte ^ pop_data_i.key_byte))
    else $error("popped entry not presented on output");

endmodule

`default_nettype wire

// ----- rtl/core/dual_lfsr_byte_masker_unit.sv -----
`default_nettype none

// Channel   Dir  Payload             Handshake
// in_i      in   data_byte   [7:0]   valid/ready
// out_o     out  masked_byte [7:0]   valid/ready
// cfg       in   cfg_idx_i, cfg_wdata_i [63:0]  cfg_we_i, no wait
//
// One byte per cycle sustained while out_o.ready is high; out_o.valid rises once an
// accepted byte has passed through the queue and then the output register.
// The eight shift steps per byte are unrolled in the generator.
// Reset loads seeds and shift registers with their defaults and empties the queue.
// A queue of QUEUE_DEPTH entries plus the output register absorbs output stalls;
// in_i.ready drops only when the queue is full.

module dual_lfsr_byte_masker_unit #(
  parameter int unsigned QUEUE_DEPTH = dlbm_pkg::QUEUE_DEPTH
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [dlbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [dlbm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  dlbm_in_if.sink                          in_i,
  dlbm_out_if.source                       out_o
);

  dlbm_pkg::q_status_t q_status;
  dlbm_pkg::entry_t    push_data;
  dlbm_pkg::entry_t    pop_data;
  logic                push;
  logic                pop;

  // Keystream generator
  dlbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .status_i    (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue
  dlbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Mask and output register
  dlbm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (q_status),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
